[sv/char_lcd_nibble_write_engine_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble write engine
// Concurrent checks sampled on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_ENGINE_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define CLCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/clcd_pkg.sv]
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and helpers shared by the LCD nibble write engine.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int BIN_W  = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W  = 4 * DIGITS;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_CHAR   = 2'd1,
    OP_NUM    = 2'd2,
    OP_CURSOR = 2'd3
  } clcd_op_t;

  localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  // start command handed to the nibble sequencer
  typedef struct packed {
    logic       start;
    logic       is_num;
    logic       rs;
    logic [7:0] byte_v;
    logic [3:0] first_idx;
  } clcd_tx_cmd_t;

  // double-dabble correction: add 3 to every BCD digit of 5 or more
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] r;
    r = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) r[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
    end
    return r;
  endfunction

  // index of the most significant nonzero digit, 0 when all are zero
  function automatic logic [3:0] lead_digit(input logic [BCD_W-1:0] bcd);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) r = 4'(i);
    end
    return r;
  endfunction

endpackage

[sv/char_lcd_nibble_write_engine_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_engine_unit
// Character LCD 4-bit bus front end: commands, characters, numbers, cursor.
// ----------------------------------------------------------------------------
// Timing: the first nibble of a command, character or cursor item passes the
//   sequencer state register and the output register; a number first runs the
//   32-step BCD converter. One item in flight: two nibble writes per byte, up to
//   ten digit bytes for a number; an output stall holds the flow.
// Reset: rst_n synchronous active low, clears sequencers and output valid.
module char_lcd_nibble_write_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_value,
  input  logic [2:0]  in_row,
  input  logic [4:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic        out_last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_TX   = 3'b100
  } top_state_t;

  top_state_t                 state_r, state_nxt;
  logic                       accept;
  logic                       cur_ok;
  logic [7:0]                 cur_addr;
  logic [1:0]                 row_idx;
  logic                       conv_start, conv_done, tx_done;
  logic [clcd_pkg::BCD_W-1:0] bcd;
  clcd_pkg::clcd_tx_cmd_t     tx_cmd;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign cur_ok   = (in_row >= 3'd1) && (in_row <= 3'd4) && (in_column <= 5'd16);
  assign row_idx  = 2'(in_row - 3'd1);
  assign cur_addr = clcd_pkg::ROW_BASE[row_idx] + {3'b0, in_column};

  always_comb begin
    state_nxt          = state_r;
    conv_start         = 1'b0;
    tx_cmd.start       = 1'b0;
    tx_cmd.is_num      = 1'b0;
    tx_cmd.rs          = 1'b0;
    tx_cmd.byte_v      = in_value[7:0];
    tx_cmd.first_idx   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (clcd_pkg::clcd_op_t'(in_op))
            clcd_pkg::OP_CMD: begin
              tx_cmd.start = 1'b1;
              state_nxt    = S_TX;
            end
            clcd_pkg::OP_CHAR: begin
              tx_cmd.start = 1'b1;
              tx_cmd.rs    = 1'b1;
              state_nxt    = S_TX;
            end
            clcd_pkg::OP_NUM: begin
              conv_start = 1'b1;
              state_nxt  = S_CONV;
            end
            clcd_pkg::OP_CURSOR: begin
              // out-of-range position drops the item
              if (cur_ok) begin
                tx_cmd.start  = 1'b1;
                tx_cmd.byte_v = cur_addr;
                state_nxt     = S_TX;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (conv_done) begin
          tx_cmd.start     = 1'b1;
          tx_cmd.is_num    = 1'b1;
          tx_cmd.rs        = 1'b1;
          tx_cmd.first_idx = clcd_pkg::lead_digit(bcd);
          state_nxt        = S_TX;
        end
      end
      S_TX: if (tx_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  clcd_bcd_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (conv_start),
    .value_i (in_value),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  clcd_tx_seq u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (tx_cmd),
    .bcd_i          (bcd),
    .done_o         (tx_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_select (out_reg_select),
    .out_nibble     (out_nibble),
    .out_last       (out_last)
  );

endmodule

[sv/clcd_bcd_conv.sv]
// ----------------------------------------------------------------------------
// clcd_bcd_conv
// Binary to BCD converter, one shift-and-correct step per cycle.
// ----------------------------------------------------------------------------
module clcd_bcd_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [clcd_pkg::BIN_W-1:0]  value_i,
  output logic                        done_o,
  output logic [clcd_pkg::BCD_W-1:0]  bcd_o
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [clcd_pkg::BIN_W-1:0] bin_r, bin_nxt;
  logic [clcd_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [clcd_pkg::BCD_W-1:0] adj;

  assign adj = clcd_pkg::bcd_adjust(bcd_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bin_nxt  = value_i;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {adj[clcd_pkg::BCD_W-2:0], bin_r[clcd_pkg::BIN_W-1]};
      bin_nxt = {bin_r[clcd_pkg::BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done_o = done_r;
  assign bcd_o  = bcd_r;

endmodule

[sv/clcd_tx_seq.sv]
// ----------------------------------------------------------------------------
// clcd_tx_seq
// Splits bytes into nibble writes, high nibble first, into an output register.
// ----------------------------------------------------------------------------
module clcd_tx_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  clcd_pkg::clcd_tx_cmd_t      cmd_i,
  input  logic [clcd_pkg::BCD_W-1:0]  bcd_i,
  output logic                        done_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_reg_select,
  output logic [3:0]                  out_nibble,
  output logic                        out_last
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_RUN  = 2'b10
  } tx_state_t;

  tx_state_t  state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_num_r, rs_r, half_r;
  logic [7:0] byte_r;
  logic [3:0] idx_r;
  logic       rs_o_r, last_o_r;
  logic [3:0] nib_o_r;
  logic [7:0] cur_byte;
  logic       load, is_last;

  assign cur_byte = is_num_r ? (clcd_pkg::ASCII_ZERO | {4'b0, bcd_i[idx_r*4 +: 4]}) : byte_r;
  assign load     = (state_r == T_RUN) && (!out_valid_r || out_ready);
  assign is_last  = half_r && (idx_r == 4'd0);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      T_IDLE: if (cmd_i.start) state_nxt = T_RUN;
      T_RUN:  if (load && is_last) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && cmd_i.start) begin
      is_num_r <= cmd_i.is_num;
      rs_r     <= cmd_i.rs;
      byte_r   <= cmd_i.byte_v;
      idx_r    <= cmd_i.first_idx;
      half_r   <= 1'b0;
    end else if (load) begin
      // numbers walk down from the leading digit
      if (half_r) idx_r <= idx_r - 4'd1;
      half_r <= ~half_r;
    end
    if (load) begin
      rs_o_r   <= rs_r;
      nib_o_r  <= half_r ? cur_byte[3:0] : cur_byte[7:4];
      last_o_r <= is_last;
    end
  end

  assign done_o         = load && is_last;
  assign out_valid      = out_valid_r;
  assign out_reg_select = rs_o_r;
  assign out_nibble     = nib_o_r;
  assign out_last       = last_o_r;

endmodule

[sv/clcd_checker.sv]
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks for the LCD nibble write engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_write_engine_unit_assert.svh"

module clcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_reg_select,
  input logic [3:0]  out_nibble,
  input logic        out_last
);

  logic take_full;

  // every op but cursor always yields at least one nibble
  assign take_full = in_valid && in_ready && (in_op != clcd_pkg::OP_CURSOR);

  `CLCD_ASSERT_NXT(a_busy_after_item, take_full, !in_ready, "input ready right after item")
  `CLCD_ASSERT_IMP(a_no_overlap, out_valid && !out_last, !in_ready,
                   "new item taken before last nibble")
  `CLCD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_nibble) && $stable(out_reg_select)
                   && $stable(out_last), "stalled nibble changed")
  `CLCD_ASSERT_IMP(a_out_drop, $fell(out_valid), $past(out_ready),
                   "output valid dropped without ready")

endmodule

bind char_lcd_nibble_write_engine_unit clcd_checker u_clcd_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the character LCD nibble write engine
// Drives command, character, number and cursor items, predicts the nibble
// writes each one causes and checks every write in order on the bus side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int FLUSH_CYCLES = 80;
  localparam int LONG_HOLD = 160;

  typedef struct packed {
    clcd_pkg::clcd_op_t op;
    logic [31:0]        value;
    logic [2:0]         row;
    logic [4:0]         column;
  } lcd_item_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } nibble_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = clcd_pkg::OP_CMD;
  logic [31:0] in_value = '0;
  logic [2:0]  in_row = '0;
  logic [4:0]  in_column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_reg_select;
  logic [3:0]  out_nibble;
  logic        out_last;

  nibble_write_t expected_writes[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;     // suppresses random idling on both sides
  int  hold_token = 0;     // bumped to request one long receiver hold-off

  char_lcd_nibble_write_engine_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_row         (in_row),
    .in_column      (in_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_select (out_reg_select),
    .out_nibble     (out_nibble),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d writes outstanding", $realtime,
               cycle_count, expected_writes.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction: bytes for one item, each split into two nibble writes
  // --------------------------------------------------------------------------
  task automatic predict_nibble_writes(input lcd_item_t it);
    logic [7:0]  bytes [10];
    logic [31:0] v;
    logic        rs;
    int          n;
    nibble_write_t w;
    n = 0;
    rs = 1'b0;
    case (it.op)
      clcd_pkg::OP_CMD: begin
        bytes[0] = it.value[7:0];
        n = 1;
      end
      clcd_pkg::OP_CHAR: begin
        bytes[0] = it.value[7:0];
        rs = 1'b1;
        n = 1;
      end
      clcd_pkg::OP_NUM: begin
        // collect digits least significant first, emit in reverse below
        v = it.value;
        rs = 1'b1;
        do begin
          bytes[n] = clcd_pkg::ASCII_ZERO + 8'(v % 10);
          v = v / 10;
          n++;
        end while (v != 0);
      end
      default: begin
        if (it.row >= 3'd1 && it.row <= 3'd4 && it.column <= 5'd16) begin
          bytes[0] = clcd_pkg::ROW_BASE[it.row - 3'd1] + 8'(it.column);
          n = 1;
        end
      end
    endcase
    for (int k = n - 1; k >= 0; k--) begin
      w.rs = rs;
      w.nibble = bytes[k][7:4];
      w.last = 1'b0;
      expected_writes.push_back(w);
      w.nibble = bytes[k][3:0];
      w.last = (k == 0);
      expected_writes.push_back(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, long hold-off on request, in-order check
  // --------------------------------------------------------------------------
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    nibble_write_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t unexpected write: rs %0b nibble %h last %0b", $realtime,
                 out_reg_select, out_nibble, out_last);
        fail_count++;
      end else begin
        exp_w = expected_writes.pop_front();
        if (out_reg_select !== exp_w.rs) begin
          $display("%0t reg_select mismatch: expected %0b actual %0b", $realtime,
                   exp_w.rs, out_reg_select);
          fail_count++;
        end
        if (out_nibble !== exp_w.nibble) begin
          $display("%0t nibble mismatch: expected %h actual %h", $realtime,
                   exp_w.nibble, out_nibble);
          fail_count++;
        end
        if (out_last !== exp_w.last) begin
          $display("%0t last mismatch: expected %0b actual %0b", $realtime,
                   exp_w.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // called at a rising edge; returns at the edge where the item is accepted,
  // leaving in_valid high so the next call can follow back to back
  task automatic send_item(input lcd_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= it.op;
    in_value  <= it.value;
    in_row    <= it.row;
    in_column <= it.column;
    do @(posedge clk); while (!in_ready);
    predict_nibble_writes(it);
  endtask

  task automatic send_fields(input clcd_pkg::clcd_op_t op, input logic [31:0] value,
                             input logic [2:0] row, input logic [4:0] column);
    lcd_item_t it;
    it.op = op;
    it.value = value;
    it.row = row;
    it.column = column;
    send_item(it);
  endtask

  task automatic wait_all_written();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  function automatic lcd_item_t random_item();
    lcd_item_t   it;
    longint      span;
    int          digits;
    it.op = clcd_pkg::clcd_op_t'($urandom_range(0, 3));
    it.value = $urandom;
    it.row = 3'($urandom_range(0, 7));
    it.column = 5'($urandom_range(0, 31));
    if (it.op == clcd_pkg::OP_NUM && $urandom_range(0, 99) < 70) begin
      // spread numbers over all lengths
      digits = $urandom_range(1, 10);
      span = 1;
      repeat (digits) span = span * 10;
      if (digits < 10) it.value = 32'(longint'(it.value) % span);
    end else if (it.op == clcd_pkg::OP_CURSOR && $urandom_range(0, 99) < 75) begin
      it.row = 3'($urandom_range(1, 4));
      it.column = 5'($urandom_range(0, 16));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_commands();
    send_fields(clcd_pkg::OP_CMD, 32'h0000_0000, 3'd0, 5'd0);
    send_fields(clcd_pkg::OP_CMD, 32'h0000_00FF, 3'd7, 5'd31);
    send_fields(clcd_pkg::OP_CMD, 32'hFFFF_FF28, 3'd2, 5'd5);  // upper bits ignored
    send_fields(clcd_pkg::OP_CMD, 32'h5A5A_A501, 3'd5, 5'd17);
  endtask

  task automatic test_characters();
    send_fields(clcd_pkg::OP_CHAR, 32'h0000_0041, 3'd0, 5'd0);
    send_fields(clcd_pkg::OP_CHAR, 32'hFFFF_FFFF, 3'd7, 5'd31);
    send_fields(clcd_pkg::OP_CHAR, 32'h1234_5600, 3'd1, 5'd16);
  endtask

  task automatic test_numbers();
    send_fields(clcd_pkg::OP_NUM, 32'd0, 3'd0, 5'd0);
    send_fields(clcd_pkg::OP_NUM, 32'd9, 3'd7, 5'd31);
    send_fields(clcd_pkg::OP_NUM, 32'd10, 3'd1, 5'd1);
    send_fields(clcd_pkg::OP_NUM, 32'd999_999_999, 3'd3, 5'd9);
    send_fields(clcd_pkg::OP_NUM, 32'd1_000_000_000, 3'd4, 5'd16);
    send_fields(clcd_pkg::OP_NUM, 32'hFFFF_FFFF, 3'd6, 5'd20);  // ten digits
  endtask

  task automatic test_cursor();
    for (int r = 1; r <= 4; r++) begin
      send_fields(clcd_pkg::OP_CURSOR, $urandom, 3'(r), 5'd0);
      send_fields(clcd_pkg::OP_CURSOR, $urandom, 3'(r), 5'd16);
    end
    // out of range: nothing comes back
    send_fields(clcd_pkg::OP_CURSOR, 32'h0, 3'd0, 5'd3);
    send_fields(clcd_pkg::OP_CURSOR, 32'hFFFF_FFFF, 3'd5, 5'd0);
    send_fields(clcd_pkg::OP_CURSOR, 32'h0, 3'd7, 5'd31);
    send_fields(clcd_pkg::OP_CURSOR, 32'h0, 3'd2, 5'd17);
    send_fields(clcd_pkg::OP_CURSOR, 32'h0, 3'd1, 5'd31);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_no_idle_stretch(input int count);
    no_idle = 1'b1;
    repeat (count) send_item(random_item());
    no_idle = 1'b0;
  endtask

  // receiver stops for a long while, the sender keeps offering items
  task automatic test_back_pressure();
    no_idle = 1'b1;
    hold_token++;
    repeat (12) send_item(random_item());
    no_idle = 1'b0;
  endtask

  // sender pauses until every write is out, then resumes
  task automatic test_drain_pause();
    repeat (15) send_item(random_item());
    wait_all_written();
    @(posedge clk);
    repeat (15) send_item(random_item());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_commands();
    test_characters();
    test_numbers();
    test_cursor();
    test_random_mix(150);
    test_back_pressure();
    test_no_idle_stretch(80);
    test_drain_pause();
    test_random_mix(60);

    wait_all_written();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
